/* rtl/emms_pkg.sv */
// Shared types, constants and helper function of the energy meter measure sequencer.
// Used by the channel interfaces, the step logic, the top level and the checker.
// Depends on nothing.
package emms_pkg;

   localparam int unsigned CROSSINGS  = 3;
   localparam int unsigned CROSS_W    = 2;
   localparam int unsigned OP_W       = 2;
   localparam int unsigned PHASE_W    = 3;
   localparam int unsigned STATUS_W   = 16;
   localparam int unsigned RMS_W      = 24;
   localparam int unsigned ENERGY_W   = 24;
   localparam int unsigned TICK_W     = 32;
   localparam int unsigned TOTAL_W    = 32;
   localparam int unsigned WAIT_W     = 16;
   localparam int unsigned BIT_IDX_W  = 4;
   localparam int unsigned CODE_W     = 5;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 24;

   localparam logic [WAIT_W-1:0]    SETTLE_RESET    = 16'd1000;
   localparam logic [WAIT_W-1:0]    INTEGRATE_RESET = 16'd1000;
   localparam logic [RMS_W-1:0]     NO_LOAD_RESET   = 24'd2184;
   localparam logic [RMS_W-1:0]     BUCKET_RESET    = 24'd6579;
   localparam logic [BIT_IDX_W-1:0] ZX_RESET        = 4'd4;
   localparam logic [BIT_IDX_W-1:0] ZXTO_RESET      = 4'd12;

   // Status code returned when no interrupt status bit is set.
   localparam logic [CODE_W-1:0] NO_STATUS = 5'd16;

   typedef enum logic [PHASE_W-1:0] {
      PH_IDLE   = 3'd0,
      PH_START  = 3'd1,
      PH_SETTLE = 3'd2,
      PH_WAIT   = 3'd3,
      PH_RMS    = 3'd4,
      PH_ENERGY = 3'd5,
      PH_DONE   = 3'd6
   } phase_type;

   typedef enum logic [OP_W-1:0] {
      OP_POLL  = 2'd0,
      OP_START = 2'd1,
      OP_ACK   = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SETTLE    = 3'd0,
      CSR_INTEGRATE = 3'd1,
      CSR_NO_LOAD   = 3'd2,
      CSR_BUCKET    = 3'd3,
      CSR_ZX_BIT    = 3'd4,
      CSR_ZXTO_BIT  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [WAIT_W-1:0]    settle_ticks;
      logic [WAIT_W-1:0]    integrate_ticks;
      logic [RMS_W-1:0]     no_load_irms;
      logic [RMS_W-1:0]     bucket_threshold;
      logic [BIT_IDX_W-1:0] zx_bit;
      logic [BIT_IDX_W-1:0] zxto_bit;
   } cfg_type;

   typedef struct packed {
      phase_type           phase;
      logic [TICK_W-1:0]   tick_count;
      logic [TICK_W-1:0]   settle_mark;
      logic [TICK_W-1:0]   window_mark;
      logic [CROSS_W-1:0]  cross_count;
      logic                metering_on;
      logic [RMS_W-1:0]    vrms;
      logic [RMS_W-1:0]    irms;
      logic [TOTAL_W-1:0]  bucket;
      logic [TOTAL_W-1:0]  total;
      logic                watt_flag;
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic                tick;
      logic                irq_line;
      logic [STATUS_W-1:0] irq_status;
      logic [RMS_W-1:0]    vrms_in;
      logic [RMS_W-1:0]    irms_in;
      logic [ENERGY_W-1:0] energy_in;
   } req_data_type;

   typedef struct packed {
      phase_type          phase;
      logic               complete;
      logic [RMS_W-1:0]   vrms_out;
      logic [RMS_W-1:0]   irms_out;
      logic [TOTAL_W-1:0] energy_total;
      logic               watt_pending;
      logic               irq_enable_req;
      logic               status_read;
      logic               energy_read;
   } rsp_data_type;

   // Index of the lowest set status bit, NO_STATUS when none is set.
   function automatic logic [CODE_W-1:0] lowest_set(input logic [STATUS_W-1:0] status);
      logic [CODE_W-1:0] code;
      code = NO_STATUS;
      for (int i = STATUS_W - 1; i >= 0; i--) begin
         if (status[i]) begin
            code = CODE_W'(i);
         end
      end
      return code;
   endfunction

endpackage

/* rtl/emms_if.sv */
// Request and response channel interfaces of the energy meter measure sequencer.
// Depends on emms_pkg for field widths.
interface emms_req_if
   import emms_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic                tick;
   logic                irq_line;
   logic [STATUS_W-1:0] irq_status;
   logic [RMS_W-1:0]    vrms_in;
   logic [RMS_W-1:0]    irms_in;
   logic [ENERGY_W-1:0] energy_in;

   modport source (
      output valid, op, tick, irq_line, irq_status, vrms_in, irms_in, energy_in,
      input  ready
   );
   modport sink (
      input  valid, op, tick, irq_line, irq_status, vrms_in, irms_in, energy_in,
      output ready
   );
endinterface

interface emms_rsp_if
   import emms_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [PHASE_W-1:0] phase;
   logic               complete;
   logic [RMS_W-1:0]   vrms_out;
   logic [RMS_W-1:0]   irms_out;
   logic [TOTAL_W-1:0] energy_total;
   logic               watt_pending;
   logic               irq_enable_req;
   logic               status_read;
   logic               energy_read;

   modport source (
      output valid, phase, complete, vrms_out, irms_out, energy_total, watt_pending,
             irq_enable_req, status_read, energy_read,
      input  ready
   );
   modport sink (
      input  valid, phase, complete, vrms_out, irms_out, energy_total, watt_pending,
             irq_enable_req, status_read, energy_read,
      output ready
   );
endinterface

/* rtl/emms_step.sv */
// Combinational step logic: next sequencer state and response for one request.
// Depends on emms_pkg.
module emms_step
   import emms_pkg::*;
(
   input  cfg_type      cfg,
   input  state_type    cur,
   input  req_data_type req,
   output state_type    nxt,
   output rsp_data_type rsp
);

   logic [TICK_W-1:0]  tick_now;
   logic [CODE_W-1:0]  code;
   logic [CROSS_W-1:0] cross_inc;
   logic [TOTAL_W-1:0] energy_val;
   logic               load;
   logic               settle_over;
   logic               window_over;
   logic               irq_en;
   logic               st_rd;
   logic               en_rd;

   always_comb begin
      tick_now    = cur.tick_count + TICK_W'(req.tick);
      code        = lowest_set(req.irq_status);
      cross_inc   = cur.cross_count + CROSS_W'(1);
      load        = req.irms_in > cfg.no_load_irms;
      // A negative energy reading counts as nothing.
      energy_val  = req.energy_in[ENERGY_W-1] ? '0 : TOTAL_W'(req.energy_in);
      settle_over = (tick_now - cur.settle_mark) >= TICK_W'(cfg.settle_ticks);
      window_over = (tick_now - cur.window_mark) >= TICK_W'(cfg.integrate_ticks);
   end

   always_comb begin
      nxt            = cur;
      nxt.tick_count = tick_now;
      irq_en         = 1'b0;
      st_rd          = 1'b0;
      en_rd          = 1'b0;
      case (req.op)
         OP_START: begin
            nxt.phase = PH_START;
         end
         OP_ACK: begin
            nxt.watt_flag = 1'b0;
         end
         OP_POLL: begin
            case (cur.phase)
               PH_START: begin
                  nxt.settle_mark = tick_now;
                  nxt.phase       = PH_SETTLE;
               end
               PH_SETTLE: begin
                  if (settle_over) begin
                     irq_en    = 1'b1;
                     nxt.phase = PH_WAIT;
                  end
               end
               PH_WAIT: begin
                  if (req.irq_line) begin
                     nxt.phase = PH_RMS;
                  end
               end
               PH_RMS: begin
                  st_rd = 1'b1;
                  if (code == CODE_W'(cfg.zx_bit)) begin
                     nxt.cross_count = cross_inc;
                     if (cross_inc == CROSS_W'(CROSSINGS)) begin
                        nxt.cross_count = '0;
                        nxt.vrms        = req.vrms_in;
                        nxt.irms        = req.irms_in;
                        nxt.phase       = PH_DONE;
                        if (!load && !cur.metering_on) begin
                           nxt.irms = '0;
                           en_rd    = 1'b1;
                        end else if (load && !cur.metering_on) begin
                           nxt.metering_on = 1'b1;
                           nxt.bucket      = cur.bucket + energy_val;
                           en_rd           = 1'b1;
                           nxt.window_mark = tick_now;
                        end else if (!load) begin
                           nxt.bucket      = cur.bucket + energy_val;
                           en_rd           = 1'b1;
                           nxt.metering_on = 1'b0;
                           nxt.phase       = PH_ENERGY;
                        end else if (window_over) begin
                           nxt.window_mark = tick_now;
                           nxt.bucket      = cur.bucket + energy_val;
                           en_rd           = 1'b1;
                           nxt.phase       = PH_ENERGY;
                        end
                     end
                  end else if (code == CODE_W'(cfg.zxto_bit)) begin
                     nxt.vrms  = '0;
                     nxt.irms  = '0;
                     nxt.phase = PH_DONE;
                  end else begin
                     nxt.phase = PH_WAIT;
                  end
               end
               PH_ENERGY: begin
                  if (cur.bucket >= TOTAL_W'(cfg.bucket_threshold)) begin
                     nxt.total     = cur.total + cur.bucket;
                     nxt.bucket    = '0;
                     nxt.watt_flag = 1'b1;
                  end
                  nxt.phase = PH_DONE;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp.phase          = nxt.phase;
      rsp.complete       = nxt.phase == PH_DONE;
      rsp.vrms_out       = nxt.vrms;
      rsp.irms_out       = nxt.irms;
      rsp.energy_total   = nxt.total;
      rsp.watt_pending   = nxt.watt_flag;
      rsp.irq_enable_req = irq_en;
      rsp.status_read    = st_rd;
      rsp.energy_read    = en_rd;
   end

endmodule

/* rtl/energy_meter_measure_sequencer.sv */
// Energy meter measure sequencer: top level with request, response and register ports.
// Depends on emms_pkg, emms_if and emms_step.
//
// Each request on the req channel is one poll of the metering front end: an op
// (poll, start, acknowledge watt step), a tick flag, the interrupt line and the
// raw status, Vrms, Irms and energy register values. Every request produces
// exactly one response on the rsp channel with the phase, the latched RMS
// values, the energy total, the watt step flag and the read/enable pulses.
// A request is captured in an input register, then the step logic updates the
// sequencer state and loads the response register as soon as that register is
// empty or its response is being taken. One request can be taken every cycle
// while the receiver keeps taking responses; the whole state update is one
// compare-and-add pass.
// When the receiver stalls, the response register holds its value and the
// input register keeps the next request; req.ready drops only when both are
// full. Reset clears the sequencer state to idle with zero counters and loads
// the default register values; csr writes are taken at any edge with csr_we
// high and must only happen while no request is in flight.
module energy_meter_measure_sequencer
   import emms_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   emms_req_if.sink              req,
   emms_rsp_if.source            rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type      cfg_ff;
   state_type    state_ff;
   state_type    state_in;
   req_data_type req_ff;
   req_data_type req_in;
   logic         req_valid_ff;
   logic         req_valid_in;
   rsp_data_type rsp_ff;
   rsp_data_type rsp_in;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   logic         advance;
   logic         take;

   always_comb begin
      advance      = req_valid_ff && (!rsp_valid_ff || rsp.ready);
      req.ready    = !req_valid_ff || advance;
      take         = req.valid && req.ready;
      req_valid_in = take || (req_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp.ready);
      req_in.op         = req.op;
      req_in.tick       = req.tick;
      req_in.irq_line   = req.irq_line;
      req_in.irq_status = req.irq_status;
      req_in.vrms_in    = req.vrms_in;
      req_in.irms_in    = req.irms_in;
      req_in.energy_in  = req.energy_in;
   end

   emms_step u_step (
      .cfg (cfg_ff),
      .cur (state_ff),
      .req (req_ff),
      .nxt (state_in),
      .rsp (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settle_ticks     <= SETTLE_RESET;
         cfg_ff.integrate_ticks  <= INTEGRATE_RESET;
         cfg_ff.no_load_irms     <= NO_LOAD_RESET;
         cfg_ff.bucket_threshold <= BUCKET_RESET;
         cfg_ff.zx_bit           <= ZX_RESET;
         cfg_ff.zxto_bit         <= ZXTO_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SETTLE:    cfg_ff.settle_ticks     <= csr_wdata[WAIT_W-1:0];
            CSR_INTEGRATE: cfg_ff.integrate_ticks  <= csr_wdata[WAIT_W-1:0];
            CSR_NO_LOAD:   cfg_ff.no_load_irms     <= csr_wdata[RMS_W-1:0];
            CSR_BUCKET:    cfg_ff.bucket_threshold <= csr_wdata[RMS_W-1:0];
            CSR_ZX_BIT:    cfg_ff.zx_bit           <= csr_wdata[BIT_IDX_W-1:0];
            CSR_ZXTO_BIT:  cfg_ff.zxto_bit         <= csr_wdata[BIT_IDX_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '{phase: PH_IDLE, default: '0};
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      rsp.valid          = rsp_valid_ff;
      rsp.phase          = rsp_ff.phase;
      rsp.complete       = rsp_ff.complete;
      rsp.vrms_out       = rsp_ff.vrms_out;
      rsp.irms_out       = rsp_ff.irms_out;
      rsp.energy_total   = rsp_ff.energy_total;
      rsp.watt_pending   = rsp_ff.watt_pending;
      rsp.irq_enable_req = rsp_ff.irq_enable_req;
      rsp.status_read    = rsp_ff.status_read;
      rsp.energy_read    = rsp_ff.energy_read;
   end

endmodule

/* rtl/emms_checker.sv */
// Port-level checker for the energy meter measure sequencer, bound to the top level.
// Depends on emms_pkg for the phase codes.
module emms_checker
   import emms_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [PHASE_W-1:0] rsp_phase,
   input logic               rsp_complete,
   input logic [TOTAL_W-1:0] rsp_energy_total,
   input logic               rsp_irq_enable_req,
   input logic               rsp_status_read,
   input logic               rsp_energy_read
);

   // A stalled response keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_phase)
         && $stable(rsp_energy_total))
      else $error("stalled response changed");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_complete == (rsp_phase == PH_DONE))
      else $error("complete flag disagrees with phase");

   // The interrupt enable pulse comes only from the settle step into waiting.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_irq_enable_req |-> rsp_phase == PH_WAIT && !rsp_status_read)
      else $error("interrupt enable outside settle exit");

   // Energy is only read on the crossing that also consumes the status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_energy_read |-> rsp_status_read
         && (rsp_phase == PH_DONE || rsp_phase == PH_ENERGY))
      else $error("energy read without status read");

endmodule

bind energy_meter_measure_sequencer emms_checker u_emms_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_phase          (rsp.phase),
   .rsp_complete       (rsp.complete),
   .rsp_energy_total   (rsp.energy_total),
   .rsp_irq_enable_req (rsp.irq_enable_req),
   .rsp_status_read    (rsp.status_read),
   .rsp_energy_read    (rsp.energy_read)
);

/* sim/testbench.sv */
// Self-checking testbench of the energy meter measure sequencer: directed and random polls,
// each response checked against a cycle-free model of the sequencer kept in this file.
// Depends on emms_pkg, the emms_req_if and emms_rsp_if interfaces and the top level.
module testbench;
   import emms_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED      = 2'd3;
   localparam int unsigned     MAX_WAIT       = 17;
   localparam int unsigned     WATCHDOG_LIMIT = 1000;
   localparam int unsigned     MAX_REPORTS    = 10;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   emms_req_if req();
   emms_rsp_if rsp();

   energy_meter_measure_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Register copies, as the block holds them after reset.
   logic [WAIT_W-1:0]    cfg_settle  = SETTLE_RESET;
   logic [WAIT_W-1:0]    cfg_window  = INTEGRATE_RESET;
   logic [RMS_W-1:0]     cfg_no_load = NO_LOAD_RESET;
   logic [RMS_W-1:0]     cfg_bucket  = BUCKET_RESET;
   logic [BIT_IDX_W-1:0] cfg_zx      = ZX_RESET;
   logic [BIT_IDX_W-1:0] cfg_zxto    = ZXTO_RESET;

   // Sequencer state of the model.
   phase_type          meter_phase    = PH_IDLE;
   logic [TICK_W-1:0]  ticks_seen     = '0;
   logic [TICK_W-1:0]  settle_start   = '0;
   logic [TICK_W-1:0]  window_start   = '0;
   logic [CROSS_W-1:0] zero_crossings = '0;
   logic               integrating    = 1'b0;
   logic [RMS_W-1:0]   vrms_held      = '0;
   logic [RMS_W-1:0]   irms_held      = '0;
   logic [TOTAL_W-1:0] energy_bucket  = '0;
   logic [TOTAL_W-1:0] energy_sum     = '0;
   logic               watt_step      = 1'b0;

   rsp_data_type readouts_due[$];
   int unsigned  failures = 0;
   int unsigned  quiet_cycles = 0;
   bit           no_idle = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int unsigned idle_draw();
      return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   task automatic report_failure(input string what);
      failures++;
      if (failures <= MAX_REPORTS) begin
         $display("tb: mismatch %0d: %s", failures, what);
      end
   endtask

   // Advances the model by one accepted request and returns the response it must produce.
   function automatic rsp_data_type meter_step(input req_data_type poll);
      rsp_data_type       readout;
      logic [CODE_W-1:0]  code;
      logic [TOTAL_W-1:0] gain;
      logic               loaded;
      readout = '0;
      code = NO_STATUS;
      for (int i = 0; i < STATUS_W; i++) begin
         if (code == NO_STATUS && poll.irq_status[i]) begin
            code = CODE_W'(i);
         end
      end
      // A negative energy reading still gets consumed but adds nothing.
      gain = poll.energy_in[ENERGY_W-1] ? '0 : TOTAL_W'(poll.energy_in);
      if (poll.tick) begin
         ticks_seen = ticks_seen + 1'b1;
      end
      case (poll.op)
         OP_START: meter_phase = PH_START;
         OP_ACK: watt_step = 1'b0;
         OP_POLL: begin
            case (meter_phase)
               PH_START: begin
                  settle_start = ticks_seen;
                  meter_phase = PH_SETTLE;
               end
               PH_SETTLE: begin
                  if (ticks_seen - settle_start >= TICK_W'(cfg_settle)) begin
                     readout.irq_enable_req = 1'b1;
                     meter_phase = PH_WAIT;
                  end
               end
               PH_WAIT: begin
                  if (poll.irq_line) begin
                     meter_phase = PH_RMS;
                  end
               end
               PH_RMS: begin
                  readout.status_read = 1'b1;
                  if (code == CODE_W'(cfg_zx)) begin
                     zero_crossings = zero_crossings + 1'b1;
                     if (zero_crossings == CROSS_W'(CROSSINGS)) begin
                        zero_crossings = '0;
                        vrms_held = poll.vrms_in;
                        irms_held = poll.irms_in;
                        meter_phase = PH_DONE;
                        loaded = poll.irms_in > cfg_no_load;
                        if (!loaded && !integrating) begin
                           irms_held = '0;
                           readout.energy_read = 1'b1;
                        end else if (loaded && !integrating) begin
                           integrating = 1'b1;
                           energy_bucket = energy_bucket + gain;
                           readout.energy_read = 1'b1;
                           window_start = ticks_seen;
                        end else if (!loaded) begin
                           energy_bucket = energy_bucket + gain;
                           readout.energy_read = 1'b1;
                           integrating = 1'b0;
                           meter_phase = PH_ENERGY;
                        end else if (ticks_seen - window_start >= TICK_W'(cfg_window)) begin
                           window_start = ticks_seen;
                           energy_bucket = energy_bucket + gain;
                           readout.energy_read = 1'b1;
                           meter_phase = PH_ENERGY;
                        end
                     end
                  end else if (code == CODE_W'(cfg_zxto)) begin
                     vrms_held = '0;
                     irms_held = '0;
                     meter_phase = PH_DONE;
                  end else begin
                     meter_phase = PH_WAIT;
                  end
               end
               PH_ENERGY: begin
                  if (energy_bucket >= TOTAL_W'(cfg_bucket)) begin
                     energy_sum = energy_sum + energy_bucket;
                     energy_bucket = '0;
                     watt_step = 1'b1;
                  end
                  meter_phase = PH_DONE;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      readout.phase = meter_phase;
      readout.complete = (meter_phase == PH_DONE);
      readout.vrms_out = vrms_held;
      readout.irms_out = irms_held;
      readout.energy_total = energy_sum;
      readout.watt_pending = watt_step;
      return readout;
   endfunction

   function automatic req_data_type req_item(input logic [OP_W-1:0] op, input logic tick,
                                             input logic irq, input logic [STATUS_W-1:0] status,
                                             input logic [RMS_W-1:0] vrms,
                                             input logic [RMS_W-1:0] irms,
                                             input logic [ENERGY_W-1:0] energy);
      req_data_type poll;
      poll.op = op;
      poll.tick = tick;
      poll.irq_line = irq;
      poll.irq_status = status;
      poll.vrms_in = vrms;
      poll.irms_in = irms;
      poll.energy_in = energy;
      return poll;
   endfunction

   // Picks a request that mostly moves the measurement forward from the current phase.
   function automatic req_data_type random_poll();
      req_data_type poll;
      int unsigned  roll;
      poll.op = OP_POLL;
      poll.tick = 1'($urandom);
      poll.irq_line = 1'($urandom);
      poll.irq_status = STATUS_W'($urandom);
      poll.vrms_in = RMS_W'($urandom);
      poll.irms_in = RMS_W'($urandom);
      poll.energy_in = ($urandom_range(0, 1) == 0) ? ENERGY_W'($urandom)
                                                   : ENERGY_W'($urandom_range(0, 4095));
      roll = $urandom_range(0, 99);
      case (meter_phase)
         PH_IDLE, PH_DONE: begin
            if (roll < 60) begin
               poll.op = OP_START;
            end else if (roll < 80) begin
               poll.op = OP_ACK;
            end else if (roll < 88) begin
               poll.op = OP_UNUSED;
            end
         end
         PH_SETTLE: poll.tick = (roll < 80);
         PH_WAIT: poll.irq_line = (roll < 70);
         PH_RMS: begin
            // Shifting clears every bit below the chosen one, so it is the lowest set bit.
            if (roll < 60) begin
               poll.irq_status = (poll.irq_status << cfg_zx) | (STATUS_W'(1) << cfg_zx);
            end else if (roll < 72) begin
               poll.irq_status = (poll.irq_status << cfg_zxto) | (STATUS_W'(1) << cfg_zxto);
            end else if (roll < 80) begin
               poll.irq_status = '0;
            end
            case ($urandom_range(0, 3))
               0: poll.irms_in = cfg_no_load;
               1: poll.irms_in = cfg_no_load + 1'b1;
               2: poll.irms_in = RMS_W'($urandom_range(0, cfg_no_load));
               default: ;
            endcase
         end
         default: ;
      endcase
      // A stray op now and then, a restart in the middle of a measurement among them.
      if ($urandom_range(0, 99) < 5) begin
         poll.op = OP_W'($urandom);
      end
      return poll;
   endfunction

   task automatic send_poll(input req_data_type poll);
      int unsigned gap;
      gap = idle_draw();
      if (gap != 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid      <= 1'b1;
      req.op         <= poll.op;
      req.tick       <= poll.tick;
      req.irq_line   <= poll.irq_line;
      req.irq_status <= poll.irq_status;
      req.vrms_in    <= poll.vrms_in;
      req.irms_in    <= poll.irms_in;
      req.energy_in  <= poll.energy_in;
      do @(posedge clock); while (!req.ready);
      readouts_due.push_back(meter_step(poll));
   endtask

   // Holds off new requests until every response in flight has come back.
   task automatic wait_readouts_drained();
      req.valid <= 1'b0;
      while (readouts_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type index,
                                 input logic [CSR_DATA_W-1:0] value);
      case (index)
         CSR_SETTLE:    cfg_settle  = value[WAIT_W-1:0];
         CSR_INTEGRATE: cfg_window  = value[WAIT_W-1:0];
         CSR_NO_LOAD:   cfg_no_load = value[RMS_W-1:0];
         CSR_BUCKET:    cfg_bucket  = value[RMS_W-1:0];
         CSR_ZX_BIT:    cfg_zx      = value[BIT_IDX_W-1:0];
         CSR_ZXTO_BIT:  cfg_zxto    = value[BIT_IDX_W-1:0];
         default: ;
      endcase
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [WAIT_W-1:0] settle, input logic [WAIT_W-1:0] window,
                            input logic [RMS_W-1:0] no_load, input logic [RMS_W-1:0] bucket,
                            input logic [BIT_IDX_W-1:0] zx, input logic [BIT_IDX_W-1:0] zxto);
      write_register(CSR_SETTLE, CSR_DATA_W'(settle));
      write_register(CSR_INTEGRATE, CSR_DATA_W'(window));
      write_register(CSR_NO_LOAD, CSR_DATA_W'(no_load));
      write_register(CSR_BUCKET, CSR_DATA_W'(bucket));
      write_register(CSR_ZX_BIT, CSR_DATA_W'(zx));
      write_register(CSR_ZXTO_BIT, CSR_DATA_W'(zxto));
   endtask

   task automatic run_random(input int unsigned count);
      for (int unsigned n = 0; n < count; n++) begin
         if (n % 64 == 0) begin
            no_idle = ($urandom_range(0, 3) == 0);
         end
         send_poll(random_poll());
      end
      no_idle = 1'b0;
      wait_readouts_drained();
   endtask

   // Reset values: after a start, the long default settle time keeps the phase in settle.
   task automatic test_reset_defaults();
      send_poll(req_item(OP_POLL, 1'b0, 1'b0, 16'h0000, 24'h000000, 24'h000000, 24'h000000));
      send_poll(req_item(OP_UNUSED, 1'b1, 1'b1, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
      send_poll(req_item(OP_ACK, 1'b0, 1'b0, 16'h0000, 24'h000000, 24'h000000, 24'h000000));
      send_poll(req_item(OP_START, 1'b0, 1'b0, 16'h0000, 24'h000000, 24'h000000, 24'h000000));
      send_poll(req_item(OP_POLL, 1'b1, 1'b0, 16'h0000, 24'h000000, 24'h000000, 24'h000000));
      send_poll(req_item(OP_POLL, 1'b1, 1'b1, 16'h0000, 24'h000000, 24'h000000, 24'h000000));
      wait_readouts_drained();
   endtask

   task automatic test_directed_cases();
      configure(16'd1, 16'd2, 24'd100, 24'd50, 4'd4, 4'd12);
      send_poll(req_item(OP_START, 1'b0, 1'b0, 16'h0000, 24'h000000, 24'h000000, 24'h000000));
      send_poll(req_item(OP_POLL, 1'b0, 1'b0, 16'h0000, 24'h000000, 24'h000000, 24'h000000));
      send_poll(req_item(OP_POLL, 1'b0, 1'b1, 16'h0000, 24'h000000, 24'h000000, 24'h000000));
      send_poll(req_item(OP_POLL, 1'b1, 1'b0, 16'h0000, 24'h000000, 24'h000000, 24'h000000));
      send_poll(req_item(OP_POLL, 1'b0, 1'b0, 16'h0010, 24'h000000, 24'h000000, 24'h000000));
      send_poll(req_item(OP_POLL, 1'b0, 1'b1, 16'h0000, 24'h000000, 24'h000000, 24'h000000));
      // No status bit set counts as an unknown cause and goes back to waiting.
      send_poll(req_item(OP_POLL, 1'b0, 1'b0, 16'h0000, 24'h000000, 24'h000000, 24'h000000));
      send_poll(req_item(OP_POLL, 1'b0, 1'b1, 16'h0000, 24'h000000, 24'h000000, 24'h000000));
      // First crossing of three: the phase stays at rms.
      send_poll(req_item(OP_POLL, 1'b0, 1'b0, 16'h0010, 24'h123456, 24'h000200, 24'h000010));
      send_poll(req_item(OP_POLL, 1'b0, 1'b0, 16'h8000, 24'h000000, 24'h000000, 24'h000000));
      send_poll(req_item(OP_POLL, 1'b0, 1'b1, 16'h0000, 24'h000000, 24'h000000, 24'h000000));
      send_poll(req_item(OP_POLL, 1'b0, 1'b0, 16'hFFF0, 24'h000000, 24'h000000, 24'h000000));
      // A restart in the middle keeps the crossing count.
      send_poll(req_item(OP_START, 1'b0, 1'b0, 16'h0000, 24'h000000, 24'h000000, 24'h000000));
      send_poll(req_item(OP_POLL, 1'b0, 1'b0, 16'h0000, 24'h000000, 24'h000000, 24'h000000));
      send_poll(req_item(OP_POLL, 1'b1, 1'b0, 16'h0000, 24'h000000, 24'h000000, 24'h000000));
      send_poll(req_item(OP_POLL, 1'b0, 1'b1, 16'h0000, 24'h000000, 24'h000000, 24'h000000));
      // Third crossing at the no-load level with a negative energy reading.
      send_poll(req_item(OP_POLL, 1'b0, 1'b0, 16'h0010, 24'hFFFFFF, 24'd100, 24'h800001));
      send_poll(req_item(OP_ACK, 1'b1, 1'b0, 16'h0000, 24'h000000, 24'h000000, 24'h000000));
      send_poll(req_item(OP_START, 1'b0, 1'b0, 16'h0000, 24'h000000, 24'h000000, 24'h000000));
      send_poll(req_item(OP_POLL, 1'b0, 1'b0, 16'h0000, 24'h000000, 24'h000000, 24'h000000));
      send_poll(req_item(OP_POLL, 1'b1, 1'b0, 16'h0000, 24'h000000, 24'h000000, 24'h000000));
      send_poll(req_item(OP_POLL, 1'b0, 1'b1, 16'h0000, 24'h000000, 24'h000000, 24'h000000));
      // Zero-cross timeout clears both RMS values.
      send_poll(req_item(OP_POLL, 1'b0, 1'b0, 16'h1000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
      wait_readouts_drained();
   endtask

   task automatic test_typical_settings();
      configure(16'd3, 16'd5, NO_LOAD_RESET, BUCKET_RESET, ZX_RESET, ZXTO_RESET);
      run_random(450);
   endtask

   task automatic test_low_extremes();
      configure(16'd0, 16'd0, 24'd0, 24'd0, 4'd0, 4'd15);
      run_random(300);
   endtask

   // The integration window never closes, so loaded crossings while integrating complete without a read.
   task automatic test_high_extremes();
      configure(16'd1, 16'hFFFF, 24'd0, 24'hFFFFFF, 4'd15, 4'd0);
      run_random(300);
   endtask

   task automatic test_long_settle();
      configure(16'hFFFF, 16'd2, 24'hFFFFFF, 24'd100, 4'd4, 4'd12);
      run_random(40);
   endtask

   // With one bit for both causes, the zero crossing takes precedence.
   task automatic test_shared_status_bit();
      configure(16'd2, 16'd4, 24'd5000, 24'd20000, 4'd7, 4'd7);
      run_random(250);
   endtask

   task automatic test_random_settings();
      for (int k = 0; k < 3; k++) begin
         configure(WAIT_W'($urandom_range(0, 6)), WAIT_W'($urandom_range(0, 20)),
                   RMS_W'($urandom), RMS_W'($urandom_range(0, 30000)),
                   BIT_IDX_W'($urandom), BIT_IDX_W'($urandom));
         run_random(60);
      end
   endtask

   initial begin
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_SETTLE;
      csr_wdata      = '0;
      req.valid      = 1'b0;
      req.op         = OP_POLL;
      req.tick       = 1'b0;
      req.irq_line   = 1'b0;
      req.irq_status = '0;
      req.vrms_in    = '0;
      req.irms_in    = '0;
      req.energy_in  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_cases();
      test_typical_settings();
      test_low_extremes();
      test_high_extremes();
      test_long_settle();
      test_shared_status_bit();
      test_random_settings();
      wait_readouts_drained();
      repeat (8) @(posedge clock);
      if (readouts_due.size() != 0) begin
         report_failure($sformatf("%0d responses never arrived", readouts_due.size()));
      end
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Takes responses after a random stall and checks each one against the oldest prediction.
   initial begin : response_check
      int unsigned  stall;
      rsp_data_type want;
      rsp.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = idle_draw();
         if (stall != 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
         if (readouts_due.size() == 0) begin
            report_failure("response without a pending request");
         end else begin
            want = readouts_due.pop_front();
            if (rsp.phase !== want.phase)
               report_failure($sformatf("phase expected %0d got %0d", want.phase, rsp.phase));
            if (rsp.complete !== want.complete)
               report_failure($sformatf("complete expected %0d got %0d",
                                        want.complete, rsp.complete));
            if (rsp.vrms_out !== want.vrms_out)
               report_failure($sformatf("vrms_out expected %h got %h",
                                        want.vrms_out, rsp.vrms_out));
            if (rsp.irms_out !== want.irms_out)
               report_failure($sformatf("irms_out expected %h got %h",
                                        want.irms_out, rsp.irms_out));
            if (rsp.energy_total !== want.energy_total)
               report_failure($sformatf("energy_total expected %h got %h",
                                        want.energy_total, rsp.energy_total));
            if (rsp.watt_pending !== want.watt_pending)
               report_failure($sformatf("watt_pending expected %0d got %0d",
                                        want.watt_pending, rsp.watt_pending));
            if (rsp.irq_enable_req !== want.irq_enable_req)
               report_failure($sformatf("irq_enable_req expected %0d got %0d",
                                        want.irq_enable_req, rsp.irq_enable_req));
            if (rsp.status_read !== want.status_read)
               report_failure($sformatf("status_read expected %0d got %0d",
                                        want.status_read, rsp.status_read));
            if (rsp.energy_read !== want.energy_read)
               report_failure($sformatf("energy_read expected %0d got %0d",
                                        want.energy_read, rsp.energy_read));
         end
      end
   end

   // Ends a hung run: too many cycles in a row with no request or response taken.
   always @(posedge clock) begin
      if ((req.valid === 1'b1 && req.ready === 1'b1)
          || (rsp.valid === 1'b1 && rsp.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

endmodule

/* sim.f */
rtl/emms_pkg.sv
rtl/emms_if.sv
rtl/emms_step.sv
rtl/energy_meter_measure_sequencer.sv
rtl/emms_checker.sv
sim/testbench.sv
